[sv/hufd_pkg.sv]
`timescale 1ns / 1ps

package hufd_pkg;

  localparam int NODE_COUNT = 512;
  localparam int IDX_W      = 9;
  localparam int SYM_W      = 8;
  localparam int CODE_W     = 8;
  localparam int CNT_W      = $clog2(CODE_W + 1);

  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 8;

  localparam logic [IDX_W-1:0] ROOT_RESET = '0;

  typedef enum logic {
    OP_NODE_WRITE = 1'b0,
    OP_DECODE     = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [SYM_W-1:0] sym;
    logic             leaf;
  } node_t;

  localparam int NODE_W = $bits(node_t);

endpackage

[sv/hufd_node_ram.sv]
`timescale 1ns / 1ps

module hufd_node_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 27,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  output logic [WIDTH-1:0]  rdata_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[sv/hufd_walker.sv]
`timescale 1ns / 1ps

module hufd_walker (
  input  logic                           clk,
  input  logic                           rst,
  // decode request
  input  logic                           req_valid,
  output logic                           req_ready,
  input  hufd_pkg::opcode_t              req_op,
  input  logic [hufd_pkg::CODE_W-1:0]    req_code,
  input  logic [hufd_pkg::IDX_W-1:0]     root_node,
  // node table read side
  output logic [hufd_pkg::IDX_W-1:0]     raddr,
  input  hufd_pkg::node_t                rd_cur,
  input  hufd_pkg::node_t                rd_root,
  // symbol output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hufd_pkg::SYM_W-1:0]     out_sym,
  output logic                           out_last
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_WALK  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t                         state, state_next;
  logic [hufd_pkg::CODE_W-1:0]    code_sh, code_sh_next;
  logic [hufd_pkg::CNT_W-1:0]     cnt, cnt_next;
  logic                           first, first_next;
  logic [hufd_pkg::IDX_W-1:0]     cursor, cursor_next;
  logic [hufd_pkg::IDX_W-1:0]     raddr_q, raddr_next;
  logic                           pend_valid, pend_valid_next;
  logic [hufd_pkg::SYM_W-1:0]     pend_sym, pend_sym_next;
  logic                           out_valid_next;
  logic [hufd_pkg::SYM_W-1:0]     out_sym_next;
  logic                           out_last_next;

  hufd_pkg::node_t                cur;
  logic                           hit;
  logic                           out_free;
  logic                           stall;
  logic                           issue;
  logic [hufd_pkg::IDX_W-1:0]     child;

  assign req_ready = (state == S_IDLE);
  assign raddr     = raddr_next;

  // the entry read back is the cursor itself on the first walk cycle, a child after that
  assign hit      = !first && rd_cur.leaf;
  assign cur      = hit ? rd_root : rd_cur;
  assign out_free = !out_valid || out_ready;
  assign stall    = hit && pend_valid && !out_free;
  assign issue    = (cnt != hufd_pkg::CNT_W'(hufd_pkg::CODE_W));
  assign child    = code_sh[hufd_pkg::CODE_W-1] ? cur.right : cur.left;

  always_comb begin
    state_next      = state;
    code_sh_next    = code_sh;
    cnt_next        = cnt;
    first_next      = first;
    cursor_next     = cursor;
    raddr_next      = raddr_q;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    out_valid_next  = out_valid && !out_ready;
    out_sym_next    = out_sym;
    out_last_next   = out_last;

    unique case (state)
      S_IDLE: begin
        if (req_valid && req_op == hufd_pkg::OP_DECODE) begin
          code_sh_next = req_code;
          cnt_next     = '0;
          state_next   = S_FETCH;
        end
      end
      S_FETCH: begin
        raddr_next = cursor;
        first_next = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (!stall) begin
          first_next = 1'b0;
          if (hit) begin
            // the previous symbol of this byte is not the last one: release it
            if (pend_valid) begin
              out_valid_next = 1'b1;
              out_sym_next   = pend_sym;
              out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_sym_next   = rd_cur.sym;
            cursor_next     = root_node;
          end
          if (issue) begin
            raddr_next   = child;
            cursor_next  = child;
            code_sh_next = {code_sh[hufd_pkg::CODE_W-2:0], 1'b0};
            cnt_next     = cnt + 1'b1;
          end else begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_valid_next  = 1'b1;
          out_sym_next    = pend_sym;
          out_last_next   = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cursor     <= hufd_pkg::ROOT_RESET;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      first      <= 1'b0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      cursor     <= cursor_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      first      <= first_next;
      cnt        <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    code_sh  <= code_sh_next;
    raddr_q  <= raddr_next;
    pend_sym <= pend_sym_next;
    out_sym  <= out_sym_next;
    out_last <= out_last_next;
  end

endmodule

[sv/huffman_tree_walk_decoder.sv]
`timescale 1ns / 1ps

// Huffman decoder walking a code tree held in a 512-entry node table.
// Input stream s_axis: tuser selects the transaction kind. A node write
// (tuser 0) stores left/right child, symbol and leaf flag at node_addr.
// A decode (tuser 1) walks the eight bits of code_byte, MSB first, from the
// cursor; every leaf reached emits its symbol on m_axis and sends the
// cursor back to root_node. tlast marks the final symbol produced by a
// byte; a byte that reaches no leaf produces nothing.
// After acceptance a decode holds tready low while it fetches the cursor
// entry, walks the code bits (one table read per code bit, each address
// depending on the entry read before it, then a test of the last node
// reached) and passes through the flush state.
// cfg_wr_en/cfg_wr_data load root_node; write it only while idle.
// Reset clears the cursor and root to node 0 and empties the output; the
// node table is not cleared and must be written before it is walked.
// When m_axis stalls, the walk holds at a leaf reached while a symbol is still
// pending until the output register frees up; s_axis tready stays low until the byte is finished.
module huffman_tree_walk_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // node_addr[8:0], left_child[17:9], right_child[26:18], leaf_symbol[34:27],
  // leaf_flag[35], code_byte[43:36], zero[47:44]
  input  logic [hufd_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // opcode[0]
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // symbol[7:0]
  output logic [hufd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_wr_en,
  input  logic [hufd_pkg::IDX_W-1:0]         cfg_wr_data
);

  localparam int IW = hufd_pkg::IDX_W;
  localparam int SW = hufd_pkg::SYM_W;
  localparam int CW = hufd_pkg::CODE_W;

  logic [IW-1:0]          root_node;
  hufd_pkg::opcode_t      op;
  logic [IW-1:0]          node_addr;
  hufd_pkg::node_t        wr_node;
  logic [CW-1:0]          code_byte;
  logic                   node_we;
  logic [IW-1:0]          raddr;
  logic [hufd_pkg::NODE_W-1:0] rdata_a;
  logic [hufd_pkg::NODE_W-1:0] rdata_b;
  logic [SW-1:0]          out_sym;

  assign op            = hufd_pkg::opcode_t'(s_axis_tuser);
  assign node_addr     = s_axis_tdata[IW-1:0];
  assign wr_node.left  = s_axis_tdata[2*IW-1:IW];
  assign wr_node.right = s_axis_tdata[3*IW-1:2*IW];
  assign wr_node.sym   = s_axis_tdata[3*IW+SW-1:3*IW];
  assign wr_node.leaf  = s_axis_tdata[3*IW+SW];
  assign code_byte     = s_axis_tdata[3*IW+SW+CW:3*IW+SW+1];

  assign node_we = s_axis_tvalid && s_axis_tready && (op == hufd_pkg::OP_NODE_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node <= hufd_pkg::ROOT_RESET;
    end else if (cfg_wr_en) begin
      root_node <= cfg_wr_data;
    end
  end

  hufd_node_ram #(
    .DEPTH (hufd_pkg::NODE_COUNT),
    .WIDTH (hufd_pkg::NODE_W)
  ) u_node_ram (
    .clk     (clk),
    .we      (node_we),
    .waddr   (node_addr),
    .wdata   (wr_node),
    .raddr_a (raddr),
    .rdata_a (rdata_a),
    .raddr_b (root_node),
    .rdata_b (rdata_b)
  );

  hufd_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req_op    (op),
    .req_code  (code_byte),
    .root_node (root_node),
    .raddr     (raddr),
    .rd_cur    (rdata_a),
    .rd_root   (rdata_b),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_sym   (out_sym),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = hufd_pkg::M_TDATA_W'(out_sym);

endmodule
